### design/onu_sleep_mode_controller_macros.svh
// Assertion macros for the ONU sleep controller checker.
// Both sample on clk and hold off while rst_n is low.
`ifndef ONU_SLEEP_MODE_CONTROLLER_MACROS_SVH
`define ONU_SLEEP_MODE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define OSMC_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/osmc_pkg.sv
package osmc_pkg;

    localparam int STATE_W = 3;

    localparam logic [STATE_W-1:0] ST_ACTIVE = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE   = 3'd1;
    localparam logic [STATE_W-1:0] ST_SLEEP  = 3'd2;
    localparam logic [STATE_W-1:0] ST_PROBE  = 3'd3;
    localparam logic [STATE_W-1:0] ST_WAKEUP = 3'd4;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKEUP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TPB    = 3'd5;

    localparam logic [1:0] MODE_HEAVY = 2'd1;

    localparam int TICK_W  = 24;
    localparam int TPB_W   = 16;
    localparam int BYTES_W = 24;
    localparam int CFG_W   = 24;

    // tx time = bytes * Q8.8 ticks, fraction dropped
    localparam int PROD_W = BYTES_W + TPB_W;
    localparam int TX_W   = PROD_W - 8;

    // floor(w / 100) = (w * DIV100_MUL) >> DIV100_SHIFT, exact for 24-bit w
    localparam int          DIV100_SHIFT = 31;
    localparam int          DIV100_MUL_W = 25;
    localparam logic [24:0] DIV100_MUL   = 25'd21474837;
    localparam int          GUARD_W      = TICK_W + 1;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [BYTES_W-1:0] queue_bytes;
        logic               sleep_request;
        logic               queue_empty;
        logic               arrival;
    } in_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]  ticks_left;
        logic               state_changed;
        logic [STATE_W-1:0] power_state;
    } out_item_t;

endpackage

### design/onu_sleep_mode_controller.sv
// An accepted request is held in the input register, then in the result register.
// Throughput: one tick request per cycle unless the output stalls; the state update
// and the sleep plan (one 24x16 multiply, subtract, saturate) sit between the two
// registers.
// Reset (rst_n low, asynchronous): ACTIVE, countdown 0, latches clear, fresh entry set,
// configuration back to defaults, both pipeline registers empty.
module onu_sleep_mode_controller #(
    parameter int TIMER_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] arrival, [1] queue_empty, [2] sleep_request, [26:3] queue_bytes, zero pad
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] power_state, [3] state_changed, [27:4] ticks_left, zero pad
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int SAT_W = (TIMER_BITS > osmc_pkg::TX_W) ? TIMER_BITS : osmc_pkg::TX_W;
    localparam logic [SAT_W-1:0] TIMER_MAX = (SAT_W'(1) << TIMER_BITS) - SAT_W'(1);
    localparam int DIV_PROD_W = osmc_pkg::TICK_W + osmc_pkg::DIV100_MUL_W;

    // configuration
    logic [1:0]                     mode_reg;
    logic [osmc_pkg::TICK_W-1:0]    idle_reg;
    logic [osmc_pkg::TICK_W-1:0]    sleep_reg;
    logic [osmc_pkg::TICK_W-1:0]    probe_reg;
    logic [osmc_pkg::TICK_W-1:0]    wakeup_reg;
    logic [osmc_pkg::TPB_W-1:0]     tpb_reg;
    logic [osmc_pkg::GUARD_W-1:0]   guard_reg;

    logic [DIV_PROD_W-1:0]          div_prod;
    logic [osmc_pkg::GUARD_W-1:0]   guard_next;

    // pipeline
    logic                           in_vld_reg;
    osmc_pkg::in_item_t             in_reg;
    logic                           out_vld_reg;
    osmc_pkg::out_item_t            out_reg;
    osmc_pkg::out_item_t            out_next;
    logic                           advance;

    // controller state
    logic [osmc_pkg::STATE_W-1:0]   state_reg, state_next;
    logic [TIMER_BITS-1:0]          cd_reg, cd_next, cd_dec;
    logic                           arr_reg, arr_next;
    logic                           req_reg, req_next;
    logic                           fresh_reg, fresh_next;
    logic [TIMER_BITS-1:0]          plan_reg, plan_next;
    logic                           expired;
    logic                           arr_now, req_now;

    // sleep plan
    logic [osmc_pkg::PROD_W-1:0]    tx_prod;
    logic [osmc_pkg::TX_W-1:0]      tx;
    logic [osmc_pkg::TX_W-1:0]      tx_diff;
    logic [SAT_W-1:0]               tx_ext;
    logic [TIMER_BITS-1:0]          plan_calc;

    assign cfg_ready = 1'b1;

    assign div_prod   = DIV_PROD_W'(cfg_data) * DIV_PROD_W'(osmc_pkg::DIV100_MUL);
    assign guard_next = osmc_pkg::GUARD_W'(cfg_data)
                      + osmc_pkg::GUARD_W'(div_prod >> osmc_pkg::DIV100_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd0;
            idle_reg   <= 24'd1000;
            sleep_reg  <= 24'd10000;
            probe_reg  <= 24'd100;
            wakeup_reg <= 24'd1000;
            tpb_reg    <= 16'd256;
            guard_reg  <= 25'd1010;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                osmc_pkg::CFG_MODE:   mode_reg <= cfg_data[1:0];
                osmc_pkg::CFG_IDLE:   idle_reg <= cfg_data;
                osmc_pkg::CFG_SLEEP:  sleep_reg <= cfg_data;
                osmc_pkg::CFG_PROBE:  probe_reg <= cfg_data;
                osmc_pkg::CFG_WAKEUP:
                begin
                    wakeup_reg <= cfg_data;
                    guard_reg  <= guard_next;
                end
                osmc_pkg::CFG_TPB:    tpb_reg <= cfg_data[osmc_pkg::TPB_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance       = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg <= s_axis_tdata[$bits(osmc_pkg::in_item_t)-1:0];
        end
        if (advance && in_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    // sleep plan from queue size
    assign tx_prod = osmc_pkg::PROD_W'(in_reg.queue_bytes) * osmc_pkg::PROD_W'(tpb_reg);
    assign tx      = tx_prod[osmc_pkg::PROD_W-1:8];
    assign tx_diff = (tx > osmc_pkg::TX_W'(guard_reg))
                   ? tx - osmc_pkg::TX_W'(guard_reg) : '0;
    assign tx_ext    = SAT_W'(tx_diff);
    assign plan_calc = TIMER_BITS'((tx_ext > TIMER_MAX) ? TIMER_MAX : tx_ext);

    assign arr_now = arr_reg | in_reg.arrival;
    assign req_now = req_reg | in_reg.sleep_request;
    assign cd_dec  = (cd_reg != '0) ? cd_reg - TIMER_BITS'(1) : cd_reg;
    assign expired = (cd_dec == '0);

    always_comb
    begin
        state_next = state_reg;
        cd_next    = cd_reg;
        arr_next   = arr_now;
        req_next   = req_now;
        fresh_next = fresh_reg;
        plan_next  = plan_reg;
        if (mode_reg == osmc_pkg::MODE_HEAVY)
        begin
            unique case (state_reg)
                osmc_pkg::ST_ACTIVE:
                begin
                    if (fresh_reg)
                    begin
                        plan_next  = plan_calc;
                        fresh_next = 1'b0;
                    end
                    if (req_now)
                    begin
                        state_next = osmc_pkg::ST_SLEEP;
                        cd_next    = plan_next;
                    end
                end
                osmc_pkg::ST_SLEEP:
                begin
                    cd_next = cd_dec;
                    if (expired)
                    begin
                        state_next = osmc_pkg::ST_WAKEUP;
                        cd_next    = TIMER_BITS'(wakeup_reg);
                    end
                end
                osmc_pkg::ST_WAKEUP:
                begin
                    cd_next = cd_dec;
                    if (expired)
                    begin
                        req_next   = 1'b0;
                        state_next = osmc_pkg::ST_ACTIVE;
                        cd_next    = '0;
                        fresh_next = 1'b1;
                    end
                end
                default:
                begin
                    state_next = osmc_pkg::ST_ACTIVE;
                    cd_next    = '0;
                    fresh_next = 1'b1;
                end
            endcase
        end
        else
        begin
            unique case (state_reg)
                osmc_pkg::ST_ACTIVE:
                begin
                    if (in_reg.queue_empty)
                    begin
                        state_next = osmc_pkg::ST_IDLE;
                        cd_next    = TIMER_BITS'(idle_reg);
                    end
                end
                osmc_pkg::ST_IDLE:
                begin
                    if (arr_now)
                    begin
                        arr_next   = 1'b0;
                        state_next = osmc_pkg::ST_ACTIVE;
                        cd_next    = '0;
                        fresh_next = 1'b1;
                    end
                    else
                    begin
                        cd_next = cd_dec;
                        if (expired)
                        begin
                            state_next = osmc_pkg::ST_SLEEP;
                            cd_next    = TIMER_BITS'(sleep_reg);
                        end
                    end
                end
                osmc_pkg::ST_SLEEP:
                begin
                    cd_next = cd_dec;
                    if (expired)
                    begin
                        state_next = osmc_pkg::ST_PROBE;
                        cd_next    = TIMER_BITS'(probe_reg);
                    end
                end
                osmc_pkg::ST_PROBE:
                begin
                    cd_next = cd_dec;
                    if (expired)
                    begin
                        if (arr_now)
                        begin
                            arr_next   = 1'b0;
                            state_next = osmc_pkg::ST_WAKEUP;
                            cd_next    = TIMER_BITS'(wakeup_reg);
                        end
                        else
                        begin
                            state_next = osmc_pkg::ST_SLEEP;
                            cd_next    = TIMER_BITS'(sleep_reg);
                        end
                    end
                end
                default:
                begin
                    cd_next = cd_dec;
                    if (expired)
                    begin
                        state_next = osmc_pkg::ST_ACTIVE;
                        cd_next    = '0;
                        fresh_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_next.power_state   = state_next;
        out_next.state_changed = (state_next != state_reg);
        out_next.ticks_left    = (state_next == osmc_pkg::ST_ACTIVE)
                               ? '0 : osmc_pkg::TICK_W'(cd_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= osmc_pkg::ST_ACTIVE;
            cd_reg    <= '0;
            arr_reg   <= 1'b0;
            req_reg   <= 1'b0;
            fresh_reg <= 1'b1;
            plan_reg  <= '0;
        end
        else if (advance && in_vld_reg)
        begin
            state_reg <= state_next;
            cd_reg    <= cd_next;
            arr_reg   <= arr_next;
            req_reg   <= req_next;
            fresh_reg <= fresh_next;
            plan_reg  <= plan_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(osmc_pkg::OUT_TDATA_W - $bits(osmc_pkg::out_item_t)){1'b0}},
                            out_reg};

endmodule

### design/osmc_checker.sv
`include "onu_sleep_mode_controller_macros.svh"

module osmc_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic [osmc_pkg::STATE_W-1:0] last_state_reg;
    osmc_pkg::out_item_t          cur;
    logic                         out_take;
    logic                         out_stall;
    logic                         active_out;
    logic                         changed_ok;

    assign cur        = m_axis_tdata[$bits(osmc_pkg::out_item_t)-1:0];
    assign out_take   = m_axis_tvalid && m_axis_tready;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign active_out = m_axis_tvalid && (cur.power_state == osmc_pkg::ST_ACTIVE);
    assign changed_ok = cur.state_changed == (cur.power_state != last_state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= osmc_pkg::ST_ACTIVE;
        end
        else if (out_take)
        begin
            last_state_reg <= cur.power_state;
        end
    end

    `OSMC_ASSERT(a_active_no_ticks, active_out, cur.ticks_left == '0, "ticks_left nonzero in ACTIVE")
    `OSMC_ASSERT(a_changed_flag, out_take, changed_ok, "state_changed off the state sequence")
    `OSMC_ASSERT(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled, output empty")
    `OSMC_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stall not held")

endmodule

bind onu_sleep_mode_controller osmc_props u_osmc_props (.*);
